// ===== hdl/bol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and codes for the bounded ordered list: request and status
// codes, field widths and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int WORD_W      = 32;
    localparam int REQ_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int MAX_RESULTS = 16;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_PAD_W   = OUT_DATA_W - WORD_W - POS_W - CNT_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_SORTED     = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_FIND       = 4'd6;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 4'd8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // cell operation
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    // which compare flag marks a hit
    typedef enum logic {
        KEY_GE,
        KEY_EQ
    } cell_key_t;

    // which cells take part in a shift
    typedef enum logic [1:0] {
        AT_ALL,
        AT_FREE,
        AT_HIT,
        AT_HIT_FREE
    } cell_at_t;

    typedef struct packed {
        cell_op_t  op;
        cell_key_t key;
        cell_at_t  at;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/bol_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bol_cell
// One list slot: holds a word, keeps its compare flags against the request
// key, and shifts toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
module bol_cell (
    input  wire                             clk,
    input  wire bol_pkg::cell_cmd_t         cmd,
    input  wire logic signed [bol_pkg::WORD_W-1:0] key,
    input  wire logic signed [bol_pkg::WORD_W-1:0] left_data,
    input  wire logic signed [bol_pkg::WORD_W-1:0] right_data,
    input  wire                             valid,
    input  wire                             seen_in,
    input  wire                             at_in,
    input  wire                             rd_sel,
    output logic signed [bol_pkg::WORD_W-1:0] data,
    output logic                            seen_out,
    output logic                            at_out,
    output logic                            first,
    output logic [bol_pkg::WORD_W-1:0]      rd_data
);
    import bol_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic                     ge_reg;
    logic                     eq_reg;
    logic                     flag;
    logic                     hit;

    assign data = data_reg;

    // hit chain: first valid cell whose flag is set
    always_comb
    begin
        unique case (cmd.key)
            KEY_GE:  flag = ge_reg;
            KEY_EQ:  flag = eq_reg;
            default: flag = eq_reg;
        endcase
        hit      = valid & flag;
        seen_out = seen_in | hit;
        first    = hit & ~seen_in;
    end

    // shift region select
    always_comb
    begin
        unique case (cmd.at)
            AT_ALL:      at_out = 1'b1;
            AT_FREE:     at_out = ~valid;
            AT_HIT:      at_out = seen_out;
            AT_HIT_FREE: at_out = seen_out | ~valid;
            default:     at_out = 1'b0;
        endcase
    end

    // masked read tap
    assign rd_data = rd_sel ? data_reg : '0;

    // storage and compare flags
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CELL_CMP:
            begin
                ge_reg <= ~(data_reg < key);
                eq_reg <= (data_reg == key);
            end
            CELL_INS:
            begin
                if (at_out)
                begin
                    data_reg <= at_in ? left_data : key;
                end
            end
            CELL_DEL:
            begin
                if (at_out)
                begin
                    data_reg <= right_data;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bounded_ordered_list_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to DEPTH signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on s_axis: tuser carries the request code, tdata the
//   word. Results leave on m_axis: tuser carries the status, tdata the
//   word, position and count, tlast marks the final result of a request.
//   Every request gives one result; a dump of a non-empty list gives one
//   result per element from the front (first 16 at most).
// Timing:
//   A request is taken in the idle state and executed in the execute
//   state once the result register can take a result. The cells compare
//   against the key in the accept cycle; the hit chain and the shift
//   resolve in the execute cycle. A dump sends one element a cycle
//   through the read tap while the result register is free.
// Reset:
//   rst_n clears the element count and the control state; cell contents
//   are not cleared and are never read until written.
// Stall:
//   The result register holds until taken; execution waits on it, and a
//   new request is taken only once the previous one has finished.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top #(
    parameter int DEPTH = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // slave side
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [bol_pkg::WORD_W-1:0]        s_axis_tdata,  // [31:0] value
    input  wire [bol_pkg::REQ_W-1:0]         s_axis_tuser,  // [3:0] req_type
    // master side
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [bol_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] word, [35:32] position,
                                                            // [40:36] count, [47:41] zero
    output logic [bol_pkg::STATUS_W-1:0]     m_axis_tuser,  // [1:0] status
    output logic                             m_axis_tlast
);
    import bol_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         req_reg, req_next;
    logic signed [WORD_W-1:0] value_reg, value_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]         dump_idx_reg, dump_idx_next;
    logic                     m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [WORD_W-1:0]        m_word_reg, m_word_next;
    logic [POS_W-1:0]         m_pos_reg, m_pos_next;
    logic [CNT_W-1:0]         m_cnt_reg, m_cnt_next;
    logic                     m_last_reg, m_last_next;

    cell_cmd_t                cmd;
    logic signed [WORD_W-1:0] cell_key;
    logic [IDX_W-1:0]         rd_idx;
    logic                     out_free;
    logic                     full;
    logic                     empty;
    logic                     found;
    logic                     dump_last;
    logic [POS_W-1:0]         hit_pos;
    logic [WORD_W-1:0]        rd_word;

    logic signed [WORD_W-1:0] data_w  [DEPTH];
    logic [WORD_W-1:0]        rd_w    [DEPTH];
    logic [DEPTH:0]           seen_w;
    logic [DEPTH:0]           at_w;
    logic [DEPTH-1:0]         first_w;
    logic [DEPTH-1:0]         valid_w;
    logic [DEPTH-1:0]         rd_sel_w;

    assign seen_w[0] = 1'b0;
    assign at_w[0]   = 1'b0;

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_d;
        logic signed [WORD_W-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = cell_key;
        end
        else
        begin : g_body
            assign left_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = data_w[i];
        end
        else
        begin : g_inner
            assign right_d = data_w[i+1];
        end

        assign valid_w[i]  = (FILL_W'(i) < fill_reg);
        assign rd_sel_w[i] = (IDX_W'(i) == rd_idx);

        bol_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .key        (cell_key),
            .left_data  (left_d),
            .right_data (right_d),
            .valid      (valid_w[i]),
            .seen_in    (seen_w[i]),
            .at_in      (at_w[i]),
            .rd_sel     (rd_sel_w[i]),
            .data       (data_w[i]),
            .seen_out   (seen_w[i+1]),
            .at_out     (at_w[i+1]),
            .first      (first_w[i]),
            .rd_data    (rd_w[i])
        );
    end

    // read tap and hit position
    always_comb
    begin
        rd_word = '0;
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | rd_w[i];
            if (first_w[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign found     = seen_w[DEPTH];
    assign out_free  = ~m_valid_reg | m_axis_tready;
    assign dump_last = ((int'(dump_idx_reg) + 1) == int'(fill_reg))
                       || (int'(dump_idx_reg) == MAX_RESULTS - 1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cell_key      = (state_reg == S_IDLE) ? s_axis_tdata : value_reg;

    // read index
    always_comb
    begin
        priority if (state_reg == S_DUMP)
        begin
            rd_idx = dump_idx_reg;
        end
        else if (req_reg == REQ_POP_BACK)
        begin
            rd_idx = IDX_W'(fill_reg - 1'b1);
        end
        else
        begin
            rd_idx = '0;
        end
    end

    // request sequencing and cell commands
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        value_next    = value_reg;
        fill_next     = fill_reg;
        dump_idx_next = dump_idx_reg;
        m_valid_next  = m_valid_reg & ~m_axis_tready;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;
        m_pos_next    = m_pos_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;
        cmd.op        = CELL_HOLD;
        cmd.key       = (req_reg == REQ_SORTED) ? KEY_GE : KEY_EQ;
        cmd.at        = AT_ALL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.op     = CELL_CMP;
                    req_next   = s_axis_tuser;
                    value_next = s_axis_tdata;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_word_next   = '0;
                    m_pos_next    = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                    unique case (req_reg)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED:
                        begin
                            if (full)
                            begin
                                m_status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.op    = CELL_INS;
                                fill_next = fill_reg + 1'b1;
                                unique case (req_reg)
                                    REQ_PUSH_FRONT: cmd.at = AT_ALL;
                                    REQ_PUSH_BACK:  cmd.at = AT_FREE;
                                    default:        cmd.at = AT_HIT_FREE;
                                endcase
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK:
                        begin
                            if (empty)
                            begin
                                m_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                m_word_next = rd_word;
                                fill_next   = fill_reg - 1'b1;
                                if (req_reg == REQ_POP_FRONT)
                                begin
                                    cmd.op = CELL_DEL;
                                    cmd.at = AT_ALL;
                                end
                            end
                        end
                        REQ_DELETE, REQ_FIND:
                        begin
                            priority if (empty)
                            begin
                                m_status_next = ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                m_status_next = ST_NOT_FOUND;
                            end
                            else if (req_reg == REQ_DELETE)
                            begin
                                m_word_next = value_reg;
                                cmd.op      = CELL_DEL;
                                cmd.at      = AT_HIT;
                                fill_next   = fill_reg - 1'b1;
                            end
                            else
                            begin
                                m_word_next = value_reg;
                                m_pos_next  = hit_pos;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        REQ_DUMP:
                        begin
                            if (empty)
                            begin
                                m_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                m_valid_next  = m_valid_reg & ~m_axis_tready;
                                dump_idx_next = '0;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    m_cnt_next = CNT_W'(fill_next);
                end
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_word_next   = rd_word;
                    m_pos_next    = POS_W'(dump_idx_reg);
                    m_cnt_next    = CNT_W'(fill_reg);
                    m_last_next   = dump_last;
                    dump_idx_next = dump_idx_reg + 1'b1;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            req_reg      <= '0;
            value_reg    <= '0;
            fill_reg     <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= ST_OK;
            m_word_reg   <= '0;
            m_pos_reg    <= '0;
            m_cnt_reg    <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            value_reg    <= value_next;
            fill_reg     <= fill_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
            m_status_reg <= m_status_next;
            m_word_reg   <= m_word_next;
            m_pos_reg    <= m_pos_next;
            m_cnt_reg    <= m_cnt_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_cnt_reg, m_pos_reg, m_word_reg};

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("element count beyond depth");

    a_first_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_w))
        else $error("more than one first hit in the cell row");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_FULL) |-> full)
        else $error("full status while list has room");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_EMPTY) |-> empty)
        else $error("empty status while list holds elements");

endmodule
`default_nettype wire
